@@ rtl/core/spgr_pkg.sv @@
// Shared types and constants for the ramped step pulse generator.
package spgr_pkg;

  localparam int unsigned CfgAddrW = 4;
  localparam int unsigned CfgDataW = 32;
  localparam int unsigned InDataW  = 16;
  localparam int unsigned OutDataW = 24;
  localparam int unsigned MsPerSec = 1000;
  localparam int unsigned RampHalf = 2;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_HIGH = 2'd1,
    PH_LOW  = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    ST_NONE     = 2'd0,
    ST_ACCEPTED = 2'd1,
    ST_REFUSED  = 2'd2
  } req_status_t;

  typedef enum logic [1:0] {
    S_IDLE  = 2'd0,
    S_CALC  = 2'd1,
    S_APPLY = 2'd2
  } ctrl_state_t;

  typedef enum logic [1:0] {
    REG_ON_TIME  = 2'd0,
    REG_OFF_TIME = 2'd1,
    REG_RATE_SPS = 2'd2,
    REG_RAMP_EN  = 2'd3
  } reg_index_t;

  typedef struct packed {
    logic [7:0] on_time_ms;
    logic [7:0] off_time_ms;
    logic [7:0] rate_sps;
    logic       ramp_en;
  } cfg_t;

  typedef struct packed {
    logic load;
    logic calc;
    logic apply;
  } dp_cmd_t;

  // Packed from the top down, so step_level lands in bit 0.
  typedef struct packed {
    logic [15:0] steps_left;
    req_status_t request_status;
    logic        busy_res;
    logic        step_level;
  } result_t;

endpackage

@@ rtl/core/spgr_regs.sv @@
// Configuration register file with its APB-style access port.
module spgr_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [spgr_pkg::CfgAddrW-1:0] paddr,
  input  logic [spgr_pkg::CfgDataW-1:0] pwdata,
  output logic [spgr_pkg::CfgDataW-1:0] prdata,
  output logic                          pready,
  output spgr_pkg::cfg_t                cfg
);
  import spgr_pkg::*;

  cfg_t       cfg_r;
  cfg_t       cfg_nxt;
  reg_index_t idx;
  logic       wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign idx    = reg_index_t'(paddr[3:2]);
  assign cfg    = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (idx)
        REG_ON_TIME:  cfg_nxt.on_time_ms  = pwdata[7:0];
        REG_OFF_TIME: cfg_nxt.off_time_ms = pwdata[7:0];
        REG_RATE_SPS: cfg_nxt.rate_sps    = pwdata[7:0];
        REG_RAMP_EN:  cfg_nxt.ramp_en     = pwdata[0];
        default:      cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_ON_TIME:  prdata = CfgDataW'(cfg_r.on_time_ms);
      REG_OFF_TIME: prdata = CfgDataW'(cfg_r.off_time_ms);
      REG_RATE_SPS: prdata = CfgDataW'(cfg_r.rate_sps);
      REG_RAMP_EN:  prdata = CfgDataW'(cfg_r.ramp_en);
      default:      prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.on_time_ms  <= 8'd1;
      cfg_r.off_time_ms <= 8'd1;
      cfg_r.rate_sps    <= 8'd0;
      cfg_r.ramp_en     <= 1'b0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

@@ rtl/core/spgr_ctrl.sv @@
// Controller state machine: sequences capture, precompute and update of each item.
module spgr_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  output logic              out_tvalid,
  input  logic              out_tready,
  output spgr_pkg::dp_cmd_t cmd
);
  import spgr_pkg::*;

  ctrl_state_t state_r;
  ctrl_state_t state_nxt;
  logic        out_valid_r;
  logic        out_valid_nxt;
  logic        slot_free;

  assign slot_free  = ~out_valid_r | out_tready;
  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    out_valid_nxt = out_valid_r & ~out_tready;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = S_CALC;
        end
      end
      S_CALC: begin
        cmd.calc  = 1'b1;
        state_nxt = S_APPLY;
      end
      S_APPLY: begin
        if (slot_free) begin
          cmd.apply     = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

@@ rtl/core/spgr_dp.sv @@
// Datapath: burst state, timing precompute, ramp arithmetic and result register.
module spgr_dp #(
  parameter int unsigned RAMP_MAX_OFFSET = 20,
  parameter int unsigned RAMP_DELTA      = 2,
  parameter int unsigned RAMP_STEP_LIMIT = 10
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  spgr_pkg::dp_cmd_t            cmd,
  input  spgr_pkg::cfg_t               cfg,
  input  logic                         in_req_type,
  input  logic [spgr_pkg::InDataW-1:0] in_step_count,
  output spgr_pkg::result_t            result
);
  import spgr_pkg::*;

  localparam logic [15:0] RampStart = 16'(RAMP_MAX_OFFSET + RAMP_DELTA);
  localparam logic [16:0] RampMax   = 17'(RAMP_MAX_OFFSET);
  localparam logic [15:0] RampStep  = 16'(RAMP_DELTA);
  localparam logic [15:0] RampLimit = 16'(RAMP_STEP_LIMIT);
  localparam logic [15:0] RampSpan  = 16'(RampHalf * RAMP_STEP_LIMIT);

  logic [9:0] recip [256];

  for (genvar g = 0; g < 256; g++) begin : g_recip
    localparam int unsigned Q = MsPerSec / ((g == 0) ? 1 : g);
    assign recip[g] = 10'(Q);
  end

  // Captured item.
  logic        req_r;
  logic [15:0] n_r;

  // Burst state.
  phase_t      phase_r, phase_nxt;
  logic [15:0] elapsed_r, elapsed_nxt;
  logic [15:0] rem_r, rem_nxt;
  logic [15:0] offs_r, offs_nxt;
  logic [15:0] rsc_r, rsc_nxt;
  logic [9:0]  gap_r, gap_nxt;

  // Precomputed values.
  logic [17:0] prod_r;
  logic [9:0]  quot_r;
  logic [17:0] lim_r;
  logic [15:0] el_inc_r;
  logic [15:0] rsc_new_r;
  logic [15:0] ramp_r;

  logic [8:0]  sum_c;
  logic [8:0]  sps_p1_c;
  logic [15:0] rsc_new_c;
  logic [15:0] base_c;
  logic [15:0] dec_c;
  logic [15:0] rs_c;
  logic [16:0] up_c;
  logic [15:0] ramp_c;

  result_t     result_r;
  req_status_t status_c;
  logic        gap_ok;
  logic        begin_c;

  assign result = result_r;

  always_comb begin
    sum_c     = {1'b0, cfg.on_time_ms} + {1'b0, cfg.off_time_ms};
    sps_p1_c  = {1'b0, cfg.rate_sps} + 9'd1;
    rsc_new_c = (n_r < RampSpan) ? (n_r >> 1) : RampLimit;
    base_c    = req_r ? RampStart : offs_r;
    dec_c     = (req_r ? n_r : rem_r) - 16'd1;
    rs_c      = req_r ? rsc_new_c : rsc_r;
    up_c      = {1'b0, base_c} + {1'b0, RampStep};
    if (dec_c < rs_c) begin
      ramp_c = (up_c > RampMax) ? RampMax[15:0] : up_c[15:0];
    end else begin
      ramp_c = (base_c > RampStep) ? (base_c - RampStep) : 16'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r <= in_req_type;
      n_r   <= in_step_count;
    end
    if (cmd.calc) begin
      prod_r    <= 18'(sps_p1_c) * 18'(sum_c);
      quot_r    <= 10'(11'(recip[cfg.rate_sps]) - 11'(sum_c));
      lim_r     <= 18'(cfg.on_time_ms) + 18'(cfg.off_time_ms) + 18'(gap_r) + 18'(offs_r);
      el_inc_r  <= (elapsed_r == 16'hFFFF) ? elapsed_r : elapsed_r + 16'd1;
      rsc_new_r <= rsc_new_c;
      ramp_r    <= ramp_c;
    end
  end

  always_comb begin
    phase_nxt   = phase_r;
    elapsed_nxt = elapsed_r;
    rem_nxt     = rem_r;
    offs_nxt    = offs_r;
    rsc_nxt     = rsc_r;
    gap_nxt     = gap_r;
    status_c    = ST_NONE;
    begin_c     = 1'b0;
    gap_ok      = (cfg.rate_sps != 8'd0) && (prod_r <= 18'(MsPerSec));
    if (req_r) begin
      if (phase_r != PH_IDLE) begin
        status_c = ST_REFUSED;
      end else begin
        status_c = ST_ACCEPTED;
        rem_nxt  = n_r;
        gap_nxt  = gap_ok ? quot_r : 10'd0;
        offs_nxt = cfg.ramp_en ? RampStart : 16'd0;
        rsc_nxt  = cfg.ramp_en ? rsc_new_r : rsc_r;
        begin_c  = 1'b1;
      end
    end else if (phase_r != PH_IDLE) begin
      elapsed_nxt = el_inc_r;
      if (phase_r == PH_HIGH) begin
        if (el_inc_r >= 16'(cfg.on_time_ms)) begin
          phase_nxt = PH_LOW;
        end
      end else if (18'(el_inc_r) >= lim_r) begin
        begin_c = 1'b1;
      end
    end
    if (begin_c) begin
      if (rem_nxt != 16'd0) begin
        elapsed_nxt = 16'd0;
        rem_nxt     = rem_nxt - 16'd1;
        if (cfg.ramp_en) begin
          offs_nxt = ramp_r;
        end
        phase_nxt = PH_HIGH;
      end else begin
        phase_nxt = PH_IDLE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_IDLE;
      elapsed_r <= '0;
      rem_r     <= '0;
      offs_r    <= '0;
      rsc_r     <= '0;
      gap_r     <= '0;
    end else if (cmd.apply) begin
      phase_r   <= phase_nxt;
      elapsed_r <= elapsed_nxt;
      rem_r     <= rem_nxt;
      offs_r    <= offs_nxt;
      rsc_r     <= rsc_nxt;
      gap_r     <= gap_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.apply) begin
      result_r.step_level     <= (phase_nxt == PH_HIGH);
      result_r.busy_res       <= (phase_nxt != PH_IDLE);
      result_r.request_status <= status_c;
      result_r.steps_left     <= rem_nxt;
    end
  end

endmodule

@@ rtl/core/step_pulse_generator_ramped.sv @@
// Top level of the ramped step pulse generator.
//
//   Group  | Direction | Contents
//   in_    | slave     | tuser = req_type, tdata = step_count
//   out_   | master    | tdata = step_level, busy_res, request_status, steps_left
//   cfg_   | slave     | on time, off time, step rate, ramp enable
//
// Each item has three steps: capture, precompute (rate multiply, reciprocal
// table, limit sum and ramp step) and state update into the output register.
// A result waiting in the output register does not block capture of the next
// item; only the update cycle waits for the register to be free.
// Reset is synchronous and clears the burst state and the handshake flags.
module step_pulse_generator_ramped #(
  parameter int unsigned RAMP_MAX_OFFSET = 20,
  parameter int unsigned RAMP_DELTA      = 2,
  parameter int unsigned RAMP_STEP_LIMIT = 10
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [spgr_pkg::InDataW-1:0]  in_tdata,   // [15:0] step_count
  input  logic                          in_tuser,   // [0] req_type
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // [0] step_level, [1] busy_res, [3:2] request_status, [19:4] steps_left
  output logic [spgr_pkg::OutDataW-1:0] out_tdata,
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [spgr_pkg::CfgAddrW-1:0] cfg_paddr,
  input  logic [spgr_pkg::CfgDataW-1:0] cfg_pwdata,
  output logic [spgr_pkg::CfgDataW-1:0] cfg_prdata,
  output logic                          cfg_pready
);
  import spgr_pkg::*;

  cfg_t    cfg;
  dp_cmd_t cmd;
  result_t result;

  assign out_tdata = OutDataW'(result);

  spgr_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  spgr_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd)
  );

  spgr_dp #(
    .RAMP_MAX_OFFSET (RAMP_MAX_OFFSET),
    .RAMP_DELTA      (RAMP_DELTA),
    .RAMP_STEP_LIMIT (RAMP_STEP_LIMIT)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .cfg           (cfg),
    .in_req_type   (in_tuser),
    .in_step_count (in_tdata),
    .result        (result)
  );

endmodule

@@ rtl/core/spgr_checker.sv @@
// Port-level checks on the result stream, bound to the top level.
module spgr_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          out_tvalid,
  input logic                          out_tready,
  input logic [spgr_pkg::OutDataW-1:0] out_tdata
);
  import spgr_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("Stalled result changed or was dropped.");

  a_reset: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("Result offered straight after reset.");

  a_high_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[0] |-> out_tdata[1])
    else $error("Step output high outside a burst.");

  a_refused_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[3:2] == ST_REFUSED) |-> out_tdata[1])
    else $error("Request refused while the block was idle.");

  a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[1] |-> (out_tdata[19:4] == 16'd0))
    else $error("Idle result reports steps left.");

endmodule

bind step_pulse_generator_ramped spgr_checker u_spgr_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
